// ===== hw/rtl/varispeed_resampler_with_static_top_assert.svh =====
// assertion macros shared by the resampler modules
`ifndef VARISPEED_RESAMPLER_WITH_STATIC_TOP_ASSERT_SVH
`define VARISPEED_RESAMPLER_WITH_STATIC_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VRS_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication, disabled in reset
`define VRS_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/vrs_pkg.sv =====
// shared types and constants of the varispeed resampler
`default_nettype none
package vrs_pkg;

  localparam int ONE_Q16   = 65536;
  localparam int STEP_MAX  = 524288;
  localparam int MAX_OUT   = 12;
  localparam int LP_COEF   = 13107;
  localparam int ADDR_BITS = 4;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_RETUNE = 2'd1;
  localparam logic [1:0] MODE_DEAD   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_AMOUNT = 2'd1;
  localparam logic [1:0] REG_DECAY  = 2'd2;
  localparam logic [1:0] REG_LEVEL  = 2'd3;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_RETUNE,
    CMD_DEAD
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic [19:0] step;
    logic [16:0] amount;
    logic [16:0] decay;
    logic [16:0] level;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vrs_cfg.sv =====
// configuration register file on the apb-style port, with knob clamping
`default_nettype none
module vrs_cfg
  import vrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [19:0] step;
  logic [16:0] amount;
  logic [16:0] decay;
  logic [16:0] level;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= 20'd65536;
      amount <= 17'd0;
      decay  <= 17'd4;
      level  <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_STEP:   step   <= pwdata[19:0];
        REG_AMOUNT: amount <= pwdata[16:0];
        REG_DECAY:  decay  <= pwdata[16:0];
        REG_LEVEL:  level  <= pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STEP:   prdata = {12'd0, step};
      REG_AMOUNT: prdata = {15'd0, amount};
      REG_DECAY:  prdata = {15'd0, decay};
      REG_LEVEL:  prdata = {15'd0, level};
    endcase
  end

  always_comb begin
    cfg.step   = (step > 20'(STEP_MAX)) ? 20'(STEP_MAX) : step;
    cfg.amount = (amount > 17'(ONE_Q16)) ? 17'(ONE_Q16) : amount;
    cfg.decay  = (decay > 17'(ONE_Q16)) ? 17'(ONE_Q16) : decay;
    cfg.level  = (level > 17'(ONE_Q16)) ? 17'(ONE_Q16) : level;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vrs_front.sv =====
// front end: accepts requests, decodes the mode and queues commands
`default_nettype none
module vrs_front
  import vrs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output qhead_t                        head,
  output logic signed [SAMPLE_BITS-1:0] head_sample,
  input  logic                          pop
);

  cmd_t                          cmd_mem [2];
  logic signed [SAMPLE_BITS-1:0] smp_mem [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          push;
  cmd_t                          cmd_dec;
  logic                          keep;

  always_comb begin
    cmd_dec = CMD_SAMPLE;
    keep    = 1'b1;
    unique case (mode)
      MODE_SAMPLE: cmd_dec = CMD_SAMPLE;
      MODE_RETUNE: cmd_dec = CMD_RETUNE;
      MODE_DEAD:   cmd_dec = CMD_DEAD;
      MODE_UNUSED: keep    = 1'b0;
    endcase
  end

  assign in_ready    = (count != 2'd2);
  assign push        = in_valid && in_ready && keep;
  assign head.valid  = (count != 2'd0);
  assign head.cmd    = cmd_mem[rd_ptr];
  assign head_sample = smp_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr] <= cmd_dec;
      smp_mem[wr_ptr] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

`include "varispeed_resampler_with_static_top_assert.svh"

  `VRS_ASSERT_IMP(a_count_bound, 1'b1, count <= 2'd2, "queue count out of range")
  `VRS_ASSERT_NXT(a_push_shows, push && !pop, head.valid, "pushed entry not visible")
  `VRS_ASSERT_NXT(a_pop_empties, pop && !push && count == 2'd1, !head.valid, "queue not empty")

endmodule
`default_nettype wire

// ===== hw/rtl/vrs_back.sv =====
// back end: resampling, noise filter and static mix sequencer with output register
`default_nettype none
module vrs_back
  import vrs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  qhead_t                        head,
  input  logic signed [SAMPLE_BITS-1:0] head_sample,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last
);

  localparam int SB = SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_LCG, S_FILT1, S_FILT2, S_NOISE, S_MIX1, S_MIX2, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PRIME_NONE, PRIME_ONE, PRIME_RUN
  } prime_t;

  localparam logic signed [15:0] LP_C = 16'(LP_COEF);

  state_t               state;
  prime_t               prime;
  logic signed [SB-1:0] cur;
  logic signed [SB-1:0] nxt;
  logic [19:0]          phase;
  logic [16:0]          burst;
  logic [31:0]          seed;
  logic signed [SB-1:0] filt;
  logic [3:0]           count;
  logic                 dead;

  logic signed [SB+17:0] st_prod;
  logic signed [SB-1:0]  station;
  logic [16:0]           share;
  logic signed [SB+16:0] lp_prod;
  logic signed [SB+17:0] noise_prod;
  logic signed [SB-1:0]  noise;
  logic signed [SB+17:0] prod_a;
  logic signed [SB+17:0] prod_b;
  logic [16:0]           mix_w;

  logic signed [SB:0]    st_diff;
  logic signed [SB-1:0]  white;
  logic signed [SB:0]    lp_diff;
  logic signed [SB+1:0]  station_sum;
  logic signed [SB+2:0]  filt_sum;
  logic signed [SB+18:0] mix_sum;
  logic signed [SB-1:0]  mix_sat;
  logic [33:0]           share_prod;
  logic [16:0]           one_minus;
  logic [19:0]           phase_dec;
  logic [20:0]           phase_inc;
  logic                  is_last;
  logic                  load;

  function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
    logic signed [SB+2:0] hi;
    logic signed [SB+2:0] lo;
    hi = $signed({4'b0000, {(SB-1){1'b1}}});
    lo = $signed({4'b1111, {(SB-1){1'b0}}});
    if (v > hi) sat = hi[SB-1:0];
    else if (v < lo) sat = lo[SB-1:0];
    else sat = v[SB-1:0];
  endfunction

  always_comb begin
    st_diff     = {nxt[SB-1], nxt} - {cur[SB-1], cur};
    white       = $signed(seed[31 -: SB]);
    lp_diff     = {white[SB-1], white} - {filt[SB-1], filt};
    station_sum = {{2{cur[SB-1]}}, cur} + $signed(st_prod[SB+17:16]);
    filt_sum    = {{3{filt[SB-1]}}, filt} + {{2{lp_prod[SB+16]}}, lp_prod[SB+16:16]};
    mix_sum     = {prod_a[SB+17], prod_a} + {prod_b[SB+17], prod_b};
    mix_sat     = sat(mix_sum[SB+18:16]);
    share_prod  = {17'd0, cfg.amount} * {17'd0, burst};
    one_minus   = 17'(ONE_Q16) - share;
    phase_dec   = (phase >= 20'(ONE_Q16)) ? (phase - 20'(ONE_Q16)) : 20'd0;
    phase_inc   = {1'b0, phase} + {1'b0, cfg.step};
    is_last     = dead || (phase_inc >= 21'(ONE_Q16)) || (count == 4'(MAX_OUT - 1));
    load        = !out_valid || out_ready;
  end

  assign pop = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prime     <= PRIME_NONE;
      cur       <= '0;
      nxt       <= '0;
      phase     <= '0;
      burst     <= '0;
      seed      <= '0;
      filt      <= '0;
      count     <= '0;
      dead      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == S_OUT && load)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            unique case (head.cmd)
              CMD_RETUNE: begin
                prime <= PRIME_NONE;
                burst <= 17'(ONE_Q16);
              end
              CMD_DEAD: begin
                prime <= PRIME_NONE;
                dead  <= 1'b1;
                state <= S_LCG;
              end
              CMD_SAMPLE: begin
                unique case (prime)
                  PRIME_NONE: begin
                    cur   <= head_sample;
                    prime <= PRIME_ONE;
                  end
                  PRIME_ONE: begin
                    nxt   <= head_sample;
                    phase <= '0;
                    prime <= PRIME_RUN;
                    dead  <= 1'b0;
                    count <= '0;
                    state <= S_LCG;
                  end
                  PRIME_RUN: begin
                    cur   <= nxt;
                    nxt   <= head_sample;
                    phase <= phase_dec;
                    dead  <= 1'b0;
                    count <= '0;
                    if (phase_dec < 20'(ONE_Q16)) state <= S_LCG;
                  end
                  default: prime <= PRIME_NONE;
                endcase
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LCG: begin
          seed    <= seed * LCG_MUL + LCG_ADD;
          st_prod <= st_diff * $signed({1'b0, phase[15:0]});
          share   <= share_prod[32:16];
          state   <= S_FILT1;
        end
        S_FILT1: begin
          lp_prod <= lp_diff * LP_C;
          station <= station_sum[SB-1:0];
          state   <= S_FILT2;
        end
        S_FILT2: begin
          filt  <= sat(filt_sum);
          state <= S_NOISE;
        end
        S_NOISE: begin
          noise_prod <= filt * $signed({1'b0, cfg.level});
          state      <= S_MIX1;
        end
        S_MIX1: begin
          noise <= noise_prod[SB+15:16];
          if (dead) begin
            prod_a <= '0;
            mix_w  <= cfg.amount;
          end else begin
            prod_a <= station * $signed({1'b0, one_minus});
            mix_w  <= share;
          end
          state <= S_MIX2;
        end
        S_MIX2: begin
          prod_b <= noise * $signed({1'b0, mix_w});
          state  <= S_OUT;
        end
        S_OUT: begin
          if (load) begin
            out_valid  <= 1'b1;
            sample_out <= mix_sat;
            last       <= is_last;
            if (dead) begin
              state <= S_IDLE;
            end else begin
              if (burst != 17'd0) burst <= (burst > cfg.decay) ? (burst - cfg.decay) : 17'd0;
              phase <= phase_inc[19:0];
              count <= count + 4'd1;
              state <= is_last ? S_IDLE : S_LCG;
            end
          end
        end
      endcase
    end
  end

`include "varispeed_resampler_with_static_top_assert.svh"

  `VRS_ASSERT_IMP(a_loop_phase, state == S_LCG && !dead, phase < 20'(ONE_Q16),
                  "phase not below one")
  `VRS_ASSERT_IMP(a_count_cap, state != S_IDLE && !dead, count <= 4'(MAX_OUT - 1),
                  "output cap overrun")
  `VRS_ASSERT_IMP(a_run_primed, state == S_LCG && !dead, prime == PRIME_RUN, "loop while unprimed")
  `VRS_ASSERT_NXT(a_dead_single, state == S_OUT && load && dead, state == S_IDLE,
                  "dead air gave more than one result")
  `VRS_ASSERT_NXT(a_load_only_out, state != S_OUT && !out_valid, !out_valid,
                  "result loaded outside output step")

endmodule
`default_nettype wire

// ===== hw/rtl/varispeed_resampler_with_static_top.sv =====
// a sample or dead-air request runs S_LCG, S_FILT1, S_FILT2, S_NOISE, S_MIX1, S_MIX2 and
//   S_OUT for each result it yields; retune and priming requests are handled in S_IDLE alone,
//   and the back end pops no new request until it is back in S_IDLE
// a 2-entry command queue lets requests be taken while the back end works or is stalled
// reset: synchronous active-high rst restores register defaults and clears the queue and sequencer state
// top level of the varispeed resampler with tuned static
`default_nettype none
module varispeed_resampler_with_static_top
  import vrs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last
);

  cfg_t                          cfg;
  qhead_t                        head;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          pop;

  vrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .sample_in   (sample_in),
    .head        (head),
    .head_sample (head_sample),
    .pop         (pop)
  );

  vrs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .head_sample (head_sample),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for the varispeed resampler: scoreboard with predictor, random requests and stalls
`timescale 1ns / 1ps
module tb;
  import vrs_pkg::*;

  localparam int SW = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 lst;
  } result_t;

  typedef enum int unsigned {UNPRIMED, ONE_HELD, RUNNING} prime_state_t;

  class resampler_scoreboard;
    longint unsigned step_reg, amount_reg, decay_reg, level_reg;
    longint cur_smp, next_smp, filt, phase, burst;
    prime_state_t prime;
    logic [31:0] seed;
    result_t expected_q[$];
    int errors;

    function new();
      step_reg = ONE_Q16;
      amount_reg = 0;
      decay_reg = 4;
      level_reg = 32768;
      cur_smp = 0;
      next_smp = 0;
      filt = 0;
      phase = 0;
      burst = 0;
      prime = UNPRIMED;
      seed = '0;
      errors = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_STEP:   step_reg = val[19:0];
        REG_AMOUNT: amount_reg = val[16:0];
        REG_DECAY:  decay_reg = val[16:0];
        REG_LEVEL:  level_reg = val[16:0];
        default: ;
      endcase
    endfunction

    function longint knob(longint unsigned v);
      return (v > ONE_Q16) ? ONE_Q16 : longint'(v);
    endfunction

    function longint saturate(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (SW - 1)) - 1;
      lo = -(longint'(1) <<< (SW - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint next_noise();
      longint white;
      seed = seed * LCG_MUL + LCG_ADD;
      white = longint'($signed(seed)) >>> (32 - SW);
      filt = saturate(filt + (((white - filt) * LP_COEF) >>> 16));
      return (filt * knob(level_reg)) >>> 16;
    endfunction

    function void push_result(longint v, logic lst);
      result_t r;
      r.smp = v[SW-1:0];
      r.lst = lst;
      expected_q.push_back(r);
    endfunction

    function void note_request(logic [1:0] md, logic signed [SW-1:0] smp);
      longint s, inc, station, share, z, mix;
      int n;
      s = smp;
      inc = (step_reg > STEP_MAX) ? STEP_MAX : longint'(step_reg);
      n = 0;
      case (md)
        MODE_RETUNE: begin
          prime = UNPRIMED;
          burst = ONE_Q16;
        end
        MODE_DEAD: begin
          z = next_noise();
          prime = UNPRIMED;
          push_result(saturate((z * knob(amount_reg)) >>> 16), 1'b1);
        end
        MODE_SAMPLE: begin
          if (prime == UNPRIMED) begin
            cur_smp = s;
            prime = ONE_HELD;
          end else begin
            if (prime == ONE_HELD) begin
              next_smp = s;
              phase = 0;
              prime = RUNNING;
            end else begin
              phase = (phase >= ONE_Q16) ? phase - ONE_Q16 : 0;
              cur_smp = next_smp;
              next_smp = s;
            end
            while (phase < ONE_Q16 && n < MAX_OUT) begin
              station = cur_smp + (((next_smp - cur_smp) * phase) >>> 16);
              share = (knob(amount_reg) * burst) >>> 16;
              z = next_noise();
              mix = (station * (ONE_Q16 - share) + z * share) >>> 16;
              if (burst > 0) begin
                burst = (burst > knob(decay_reg)) ? burst - knob(decay_reg) : 0;
              end
              phase += inc;
              n++;
              push_result(saturate(mix), !(phase < ONE_Q16 && n < MAX_OUT));
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [SW-1:0] smp, logic lst);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output sample %0d last %0b", smp, lst));
        return;
      end
      e = expected_q.pop_front();
      if (smp !== e.smp) begin
        report_mismatch($sformatf("sample_out %0d, expected %0d", smp, e.smp));
      end
      if (lst !== e.lst) begin
        report_mismatch($sformatf("last %0b, expected %0b", lst, e.lst));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata, prdata;
  logic                 pready;
  logic                 in_valid, in_ready;
  logic [1:0]           mode;
  logic signed [SW-1:0] sample_in;
  logic                 out_valid, out_ready;
  logic signed [SW-1:0] sample_out;
  logic                 last;

  resampler_scoreboard sb;
  int send_pct;
  int stall_pct;
  int quiet_cycles;

  varispeed_resampler_with_static_top #(.SAMPLE_BITS(SW)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out), .last(last)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((out_valid && out_ready) || (in_valid && in_ready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (out_valid && out_ready) sb.check_result(sample_out, last);
      if (in_valid && in_ready) sb.note_request(mode, sample_in);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task write_config(logic [31:0] step, logic [31:0] amount, logic [31:0] decay,
                    logic [31:0] level);
    apb_write(REG_STEP, step);
    apb_write(REG_AMOUNT, amount);
    apb_write(REG_DECAY, decay);
    apb_write(REG_LEVEL, level);
  endtask

  task send_request(logic [1:0] md, logic signed [SW-1:0] smp);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task random_request();
    int r;
    logic [SW-1:0] smp;
    r = $urandom_range(99);
    smp = SW'($urandom);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: smp = {1'b0, {(SW-1){1'b1}}};
        1: smp = {1'b1, {(SW-1){1'b0}}};
        2: smp = '0;
        default: smp = '1;
      endcase
    end
    if (r < 5) send_request(MODE_RETUNE, smp);
    else if (r < 9) send_request(MODE_DEAD, smp);
    else if (r < 11) send_request(MODE_UNUSED, smp);
    else send_request(MODE_SAMPLE, smp);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task run_phase(logic [31:0] step, logic [31:0] amount, logic [31:0] decay,
                 logic [31:0] level, int sp, int rp, int count);
    write_config(step, amount, decay, level);
    send_pct = sp;
    stall_pct = rp;
    repeat (count) random_request();
    drain();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = MODE_SAMPLE;
    sample_in = '0;
    out_ready = 1'b0;
    send_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // half speed, amount and level knobs above full scale
    write_config(32'd32768, 32'h1FFFF, 32'd4096, 32'h1FFFF);
    send_request(MODE_RETUNE, 16'sd0);
    send_request(MODE_SAMPLE, 16'sd32767);
    send_request(MODE_SAMPLE, -16'sd32768);
    send_request(MODE_SAMPLE, 16'sd32767);
    send_request(MODE_SAMPLE, 16'sd0);
    send_request(MODE_UNUSED, 16'sd5);
    send_request(MODE_DEAD, 16'sd0);
    send_request(MODE_SAMPLE, -16'sd32768);
    send_request(MODE_SAMPLE, -16'sd1);
    send_request(MODE_SAMPLE, 16'sd1);
    send_request(MODE_RETUNE, -16'sd1);
    send_request(MODE_SAMPLE, 16'sd32767);
    send_request(MODE_SAMPLE, 16'sd32767);
    send_request(MODE_DEAD, 16'sd0);
    send_request(MODE_DEAD, 16'sd0);
    send_request(MODE_SAMPLE, 16'sd0);
    send_request(MODE_SAMPLE, -16'sd32768);
    send_request(MODE_SAMPLE, 16'sd32767);
    drain();

    // output cap, then step above range
    write_config(32'd5461, 32'd65536, 32'd0, 32'd65536);
    send_request(MODE_RETUNE, 16'sd0);
    send_request(MODE_SAMPLE, -16'sd32768);
    send_request(MODE_SAMPLE, 16'sd32767);
    send_request(MODE_SAMPLE, -16'sd32768);
    drain();
    apb_write(REG_STEP, 32'hFFFFF);
    send_request(MODE_SAMPLE, 16'sd100);
    send_request(MODE_SAMPLE, -16'sd100);
    drain();

    run_phase(32'd65536, 32'd0, 32'd4, 32'd32768, 0, 0, 50);
    run_phase(32'd5461, 32'd65536, 32'd0, 32'd65536, 53, 0, 50);
    run_phase(32'd524288, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 0, 53, 50);
    run_phase(32'hFFFFF, $urandom_range(32'h1FFFF), $urandom_range(32'h1FFFF), 32'd0,
              38, 38, 50);
    run_phase($urandom_range(5462, STEP_MAX), $urandom_range(32'h1FFFF),
              $urandom_range(32'h1FFFF), $urandom_range(32'h1FFFF), 0, 0, 50);
    run_phase(32'd0, 32'd32768, 32'd65536, 32'd65536, 38, 38, 50);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
